>>> rtl/bpsm_pkg.sv
package bpsm_pkg;

    typedef logic [7:0] byte_t;

    localparam int COUNT_W = 32;
    localparam int LEN_W   = 5;
    localparam int CFG_W   = 3;
    localparam int DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_SEARCH_MODE    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_PATTERN_LOW    = 3'd1;
    localparam logic [CFG_W-1:0] CFG_PATTERN_HIGH   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_W-1:0] CFG_SEARCH_FROM    = 3'd4;

    localparam byte_t UPPER_A     = 8'd65;
    localparam byte_t UPPER_Z     = 8'd90;
    localparam byte_t CASE_OFFSET = 8'd32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_buffer;
        logic       end_of_buffer;
    } search_item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] match_offset;
        logic [LEN_W-1:0]   match_length;
    } result_item_t;

    function automatic byte_t fold_letter(input byte_t b);
        byte_t r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z)
        begin
            r = byte_t'(b + CASE_OFFSET);
        end
        return r;
    endfunction

endpackage

>>> rtl/bpsm_cell.sv
module bpsm_cell #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                 clk,
    input  logic                                 shift,
    input  logic                                 text_mode,
    input  bpsm_pkg::byte_t                      byte_in,
    input  bpsm_pkg::byte_t [MAX_PATTERN-1:0]    pattern,
    output bpsm_pkg::byte_t                      byte_out,
    output logic [MAX_PATTERN-1:0]               eq,
    output logic                                 is_zero
);
    import bpsm_pkg::*;

    byte_t byte_reg;
    byte_t byte_next;
    byte_t cmp_byte;

    // Compare the byte this cell takes on the coming shift
    always_comb
    begin
        cmp_byte = text_mode ? fold_letter(byte_in) : byte_in;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            eq[i] = (cmp_byte == pattern[i]);
        end
        is_zero = (byte_in == 8'd0);
    end

    assign byte_next = shift ? byte_in : byte_reg;
    assign byte_out  = byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

>>> rtl/bpsm_resolve.sv
module bpsm_resolve #(
    parameter int MAX_PATTERN = 16,
    localparam int WIN = 2 * MAX_PATTERN - 1,
    localparam int DW  = (WIN > 1) ? $clog2(WIN) : 1
) (
    input  logic [WIN-1:0][MAX_PATTERN-1:0]      eq_all,
    input  logic [WIN-1:0]                       zero_all,
    input  logic                                 text_mode,
    input  logic [bpsm_pkg::LEN_W-1:0]           len,
    input  logic [bpsm_pkg::COUNT_W-1:0]         offset,
    input  logic [bpsm_pkg::COUNT_W-1:0]         search_from,
    input  logic                                 eob,
    output logic                                 hit,
    output logic [DW-1:0]                        hit_dist
);
    import bpsm_pkg::*;

    logic [LEN_W:0]     span_w;
    logic [DW-1:0]      span1;
    logic [DW-1:0]      lim;
    logic [DW-1:0]      dcap;
    logic [DW-1:0]      cap;
    logic [COUNT_W-1:0] diff;
    logic               from_ok;
    logic [WIN-1:0]     narrow;
    logic [WIN-1:0]     wide;
    logic [WIN-1:0]     elig;

    // Distance d means a start at offset - d
    always_comb
    begin
        span_w  = text_mode ? ({1'b0, len} + {1'b0, len} - (LEN_W+1)'(2))
                            : ({1'b0, len} - (LEN_W+1)'(1));
        span1   = DW'(span_w);
        lim     = (offset >= COUNT_W'(span1)) ? span1 : offset[DW-1:0];
        from_ok = (offset >= search_from);
        diff    = offset - search_from;
        dcap    = (diff >= COUNT_W'(WIN - 1)) ? DW'(WIN - 1) : diff[DW-1:0];
        cap     = (lim < dcap) ? lim : dcap;
    end

    always_comb
    begin
        for (int d = 0; d < WIN; d++)
        begin
            narrow[d] = 1'b1;
            wide[d]   = text_mode;
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                if (LEN_W'(i) < len)
                begin
                    if (i <= d)
                    begin
                        narrow[d] = narrow[d] & eq_all[d-i][i];
                    end
                    else
                    begin
                        narrow[d] = 1'b0;
                    end
                    if (2 * i <= d)
                    begin
                        wide[d] = wide[d] & eq_all[d-2*i][i];
                        if (i > 0)
                        begin
                            wide[d] = wide[d] & zero_all[d-2*i+1];
                        end
                    end
                    else
                    begin
                        wide[d] = 1'b0;
                    end
                end
            end
            elig[d] = from_ok && (DW'(d) <= cap) && (eob || DW'(d) == span1);
        end
    end

    // Largest distance wins: earliest start
    always_comb
    begin
        hit      = 1'b0;
        hit_dist = '0;
        for (int d = 0; d < WIN; d++)
        begin
            if (elig[d] && (narrow[d] || wide[d]))
            begin
                hit      = 1'b1;
                hit_dist = DW'(d);
            end
        end
    end

endmodule

>>> rtl/byte_pattern_search_matcher.sv
// Channel   Handshake                 Payload
// byte      byte_valid / byte_stall   byte_item   (data_byte, start/end marks)
// result    result_valid / result_stall result_item (found, offset, length)
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data (ready always high)
//
// One byte per cycle while byte_stall is low: each byte enters the cell
// chain at acceptance, and the match across all window starts resolves in
// that same cycle. A result passes through the resolve register, then the
// offset subtract into the output register, then leaves on the result port.
// Reset is asynchronous and clears configuration (pattern length to 1), byte
// count and pass state. byte_stall rises only while the resolve register is
// full and the output register is held by result_stall.
module byte_pattern_search_matcher #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  bpsm_pkg::search_item_t        byte_item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output bpsm_pkg::result_item_t        result_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpsm_pkg::CFG_W-1:0]    cfg_index,
    input  logic [bpsm_pkg::DATA_W-1:0]   cfg_data
);
    import bpsm_pkg::*;

    localparam int WIN = 2 * MAX_PATTERN - 1;
    localparam int DW  = (WIN > 1) ? $clog2(WIN) : 1;

    logic               mode_reg, mode_next;
    logic [DATA_W-1:0]  pat_low_reg, pat_low_next;
    logic [DATA_W-1:0]  pat_high_reg, pat_high_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic [COUNT_W-1:0] from_reg, from_next;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_found_reg, s1_found_next;
    logic [COUNT_W-1:0] s1_offset_reg, s1_offset_next;
    logic [DW-1:0]      s1_dist_reg, s1_dist_next;
    logic [LEN_W-1:0]   s1_len_reg, s1_len_next;

    logic               out_valid_reg, out_valid_next;
    result_item_t       out_item_reg, out_item_next;

    logic [LEN_W-1:0]   used_len;
    logic [2*DATA_W-1:0] pat_all;
    byte_t [MAX_PATTERN-1:0] pattern;
    byte_t [WIN-1:0]    win_byte;
    logic [WIN-1:0][MAX_PATTERN-1:0] eq_all;
    logic [WIN-1:0]     zero_all;

    logic               accept;
    logic               sob;
    logic               eob;
    logic               done_eff;
    logic               shift;
    logic               usable;
    logic [COUNT_W-1:0] offset;
    logic               hit;
    logic [DW-1:0]      hit_dist;
    logic               produce;
    logic               s1_move;

    // Configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next     = mode_reg;
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        plen_next     = plen_reg;
        from_next     = from_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEARCH_MODE:    mode_next     = cfg_data[0];
                CFG_PATTERN_LOW:    pat_low_next  = cfg_data;
                CFG_PATTERN_HIGH:   pat_high_next = cfg_data;
                CFG_PATTERN_LENGTH: plen_next     = cfg_data[LEN_W-1:0];
                CFG_SEARCH_FROM:    from_next     = cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (plen_reg == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (plen_reg > LEN_W'(MAX_PATTERN))
        begin
            used_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = plen_reg;
        end
    end

    assign pat_all = {pat_high_reg, pat_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pattern[i] = pat_all[8*i +: 8];
        end
    end

    // Handshake and pass control
    assign s1_move    = !out_valid_reg || !result_stall;
    assign byte_stall = s1_valid_reg && !s1_move;
    assign accept     = byte_valid && !byte_stall;
    assign sob        = byte_item.start_of_buffer;
    assign eob        = byte_item.end_of_buffer;
    assign done_eff   = done_reg && !sob;
    assign shift      = accept && !done_eff;
    assign offset     = sob ? '0 : count_reg;
    assign usable     = (offset != '1);
    assign produce    = shift && ((usable && hit) || eob);

    // Cell chain: cell k holds the byte at distance k from the newest
    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        byte_t cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = byte_item.data_byte;
        end
        else
        begin : g_body
            assign cell_in = win_byte[k-1];
        end

        bpsm_cell #(
            .MAX_PATTERN (MAX_PATTERN)
        ) u_cell (
            .clk       (clk),
            .shift     (shift),
            .text_mode (mode_reg),
            .byte_in   (cell_in),
            .pattern   (pattern),
            .byte_out  (win_byte[k]),
            .eq        (eq_all[k]),
            .is_zero   (zero_all[k])
        );
    end

    bpsm_resolve #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_resolve (
        .eq_all      (eq_all),
        .zero_all    (zero_all),
        .text_mode   (mode_reg),
        .len         (used_len),
        .offset      (offset),
        .search_from (from_reg),
        .eob         (eob),
        .hit         (hit),
        .hit_dist    (hit_dist)
    );

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (accept)
        begin
            done_next = done_eff || produce;
            if (shift)
            begin
                count_next = usable ? offset + COUNT_W'(1) : offset;
            end
        end
    end

    // Resolve register, then output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg && !s1_move;
        s1_found_next  = s1_found_reg;
        s1_offset_next = s1_offset_reg;
        s1_dist_next   = s1_dist_reg;
        s1_len_next    = s1_len_reg;
        if (produce)
        begin
            s1_valid_next  = 1'b1;
            s1_found_next  = usable && hit;
            s1_offset_next = offset;
            s1_dist_next   = hit_dist;
            s1_len_next    = used_len;
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
            out_item_next.found        = s1_found_reg;
            out_item_next.match_offset = s1_found_reg
                ? s1_offset_reg - COUNT_W'(s1_dist_reg) : '0;
            out_item_next.match_length = s1_found_reg ? s1_len_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            plen_reg      <= LEN_W'(1);
            from_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            plen_reg      <= plen_next;
            from_reg      <= from_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_found_reg  <= s1_found_next;
        s1_offset_reg <= s1_offset_next;
        s1_dist_reg   <= s1_dist_next;
        s1_len_reg    <= s1_len_next;
        out_item_reg  <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

`ifndef SYNTHESIS
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.found |->
            result_item.match_offset == '0 && result_item.match_length == '0)
        else $error("not-found result carries nonzero fields");

    a_found_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.found |->
            result_item.match_length != '0 &&
            result_item.match_length <= LEN_W'(MAX_PATTERN))
        else $error("found result length out of range");

    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> done_reg)
        else $error("pass not closed after its result");

    a_count_advance: assert property (@(posedge clk) disable iff (!rst_n)
        shift && usable |=> count_reg == $past(offset) + COUNT_W'(1))
        else $error("byte count did not advance");
`endif

endmodule
